// ----- design/qvt_pkg.sv -----
// Shared types, codes and defaults for the quorum vote tally block.
package qvt_pkg;

    // Field widths fixed by the beat format.
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned CFG_W  = 4;
    localparam int unsigned CIDX_W = 2;

    // Defaults for the top-level parameters and the register reset values.
    localparam int unsigned SUBQUORUM_SIZE_DEFAULT = 10;
    localparam int unsigned NUM_SUBQUORUMS_DEFAULT = 2;
    localparam int unsigned ACTIVE_SIZE_RESET      = 10;
    localparam int unsigned MIN_VOTES_RESET        = 7;

    // Command codes carried in the input tuser.
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_VOTE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_ACTIVE_FIRST  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ACTIVE_SECOND = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MIN_VOTES     = 2'd2;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_APPROVED = 2'd1,
        ST_REJECTED = 2'd2
    } slot_state_t;

    // Command from the decoder to one subquorum lane.
    typedef struct packed {
        logic             clear;
        logic             vote;
        logic [POS_W-1:0] pos;
        logic             approve;
    } lane_cmd_t;

    // Status from a lane: whether the vote landed, and the counts after this beat.
    typedef struct packed {
        logic             recorded;
        logic [CNT_W-1:0] approve_cnt;
        logic [CNT_W-1:0] reject_cnt;
    } lane_stat_t;

endpackage

// ----- design/qvt_lane.sv -----
// One subquorum: its voter slots and its running approve and reject counters.
module qvt_lane #(
    parameter int unsigned SUBQUORUM_SIZE = qvt_pkg::SUBQUORUM_SIZE_DEFAULT,
    parameter int unsigned RESET_ACT      = qvt_pkg::SUBQUORUM_SIZE_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qvt_pkg::lane_cmd_t       cmd,
    input  logic [qvt_pkg::CNT_W-1:0] act_size,
    output qvt_pkg::lane_stat_t      stat
);

    localparam int unsigned SLOT_IDX_W = (SUBQUORUM_SIZE > 1) ? $clog2(SUBQUORUM_SIZE) : 1;

    qvt_pkg::slot_state_t slot_reg [SUBQUORUM_SIZE];
    logic [qvt_pkg::CNT_W-1:0] approve_cnt_reg;
    logic [qvt_pkg::CNT_W-1:0] approve_cnt_next;
    logic [qvt_pkg::CNT_W-1:0] reject_cnt_reg;
    logic [qvt_pkg::CNT_W-1:0] reject_cnt_next;
    logic [SLOT_IDX_W-1:0]     slot_idx;
    logic                      hit;

    // The decoder only raises vote for a position inside the subquorum.
    assign slot_idx = cmd.pos[SLOT_IDX_W-1:0];
    assign hit      = cmd.vote && (slot_reg[slot_idx] == qvt_pkg::ST_NONE);

    always_comb
    begin
        approve_cnt_next = approve_cnt_reg;
        reject_cnt_next  = reject_cnt_reg;
        if (cmd.clear)
        begin
            approve_cnt_next = '0;
            reject_cnt_next  = qvt_pkg::CNT_W'(SUBQUORUM_SIZE) - act_size;
        end
        else if (hit)
        begin
            if (cmd.approve)
            begin
                approve_cnt_next = approve_cnt_reg + 1'b1;
            end
            else
            begin
                reject_cnt_next = reject_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(SUBQUORUM_SIZE); i++)
            begin
                slot_reg[i] <= (i >= int'(RESET_ACT)) ? qvt_pkg::ST_REJECTED
                                                      : qvt_pkg::ST_NONE;
            end
            approve_cnt_reg <= '0;
            reject_cnt_reg  <= qvt_pkg::CNT_W'(SUBQUORUM_SIZE - RESET_ACT);
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < int'(SUBQUORUM_SIZE); i++)
                begin
                    slot_reg[i] <= (i >= int'(act_size)) ? qvt_pkg::ST_REJECTED
                                                         : qvt_pkg::ST_NONE;
                end
            end
            else if (hit)
            begin
                slot_reg[slot_idx] <= cmd.approve ? qvt_pkg::ST_APPROVED
                                                  : qvt_pkg::ST_REJECTED;
            end
            approve_cnt_reg <= approve_cnt_next;
            reject_cnt_reg  <= reject_cnt_next;
        end
    end

    assign stat.recorded    = hit && !cmd.clear;
    assign stat.approve_cnt = approve_cnt_next;
    assign stat.reject_cnt  = reject_cnt_next;

    // A recorded vote raises exactly one of the two counters by one.
    a_one_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        stat.recorded |=> (5'(approve_cnt_reg) + 5'(reject_cnt_reg)
                           == 5'($past(approve_cnt_reg)) + 5'($past(reject_cnt_reg)) + 5'd1))
        else $error("recorded vote did not advance the counters by one");

    // A clear leaves the counters at zero approvals and the pre-rejected slots.
    a_clear_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (approve_cnt_reg == '0)
                      && (reject_cnt_reg == qvt_pkg::CNT_W'(SUBQUORUM_SIZE) - $past(act_size)))
        else $error("counters wrong after clear");

endmodule

// ----- design/quorum_vote_tally_top.sv -----
// Top level of the quorum vote tally: beat decode, subquorum lanes and result register.
//
// Each input beat is either a clear, which starts a new tally, or a vote into one slot of
// one subquorum. The block takes at most one beat per clock cycle and returns exactly one
// registered result beat for it: the slot lookup, the counter update and both tally flags
// are settled in a single pass from the per-subquorum slot registers and counters into
// the result register. The result register frees itself in the cycle it is taken, so a
// downstream sink that is always ready sees a steady rate of one result per cycle. Active
// sizes take effect at the next clear; the minimum vote count acts at once.
module quorum_vote_tally_top #(
    parameter int unsigned SUBQUORUM_SIZE = qvt_pkg::SUBQUORUM_SIZE_DEFAULT,
    parameter int unsigned NUM_SUBQUORUMS = qvt_pkg::NUM_SUBQUORUMS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // slot_position[3:0], vote_approve[4], zero
    input  logic [1:0]                 s_tuser,   // command[0], subquorum[1]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // recorded, arg_error, tally_approved,
                                                  // tally_rejected, then zero
    input  logic                       cfg_we,
    input  logic [qvt_pkg::CIDX_W-1:0] cfg_index,
    input  logic [qvt_pkg::CFG_W-1:0]  cfg_data
);

    localparam int unsigned RESET_ACT = (qvt_pkg::ACTIVE_SIZE_RESET > SUBQUORUM_SIZE)
                                        ? SUBQUORUM_SIZE : qvt_pkg::ACTIVE_SIZE_RESET;
    localparam int unsigned CNT_W = qvt_pkg::CNT_W;

    logic [CNT_W-1:0] act_first_reg;
    logic [CNT_W-1:0] act_second_reg;
    logic [CNT_W-1:0] min_votes_reg;
    logic [CNT_W-1:0] act_first_sat;
    logic [CNT_W-1:0] act_second_sat;

    logic                      accept;
    logic                      cmd_in;
    logic                      subq_in;
    logic [qvt_pkg::POS_W-1:0] pos_in;
    logic                      approve_in;
    logic                      in_range;
    logic                      arg_error;
    logic                      recorded;
    logic                      tally_approved;
    logic                      tally_rejected;

    qvt_pkg::lane_cmd_t  lane_cmd  [NUM_SUBQUORUMS];
    qvt_pkg::lane_stat_t lane_stat [NUM_SUBQUORUMS];

    logic       out_valid_reg;
    logic [3:0] out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_first_reg  <= CNT_W'(qvt_pkg::ACTIVE_SIZE_RESET);
            act_second_reg <= CNT_W'(qvt_pkg::ACTIVE_SIZE_RESET);
            min_votes_reg  <= CNT_W'(qvt_pkg::MIN_VOTES_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qvt_pkg::REG_ACTIVE_FIRST:  act_first_reg  <= cfg_data;
                qvt_pkg::REG_ACTIVE_SECOND: act_second_reg <= cfg_data;
                qvt_pkg::REG_MIN_VOTES:     min_votes_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign act_first_sat  = (int'(act_first_reg) > int'(SUBQUORUM_SIZE))
                            ? CNT_W'(SUBQUORUM_SIZE) : act_first_reg;
    assign act_second_sat = (int'(act_second_reg) > int'(SUBQUORUM_SIZE))
                            ? CNT_W'(SUBQUORUM_SIZE) : act_second_reg;

    // Beat decode.
    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign cmd_in     = s_tuser[0];
    assign subq_in    = s_tuser[1];
    assign pos_in     = s_tdata[3:0];
    assign approve_in = s_tdata[4];
    assign in_range   = (int'(subq_in) < int'(NUM_SUBQUORUMS))
                        && (int'(pos_in) < int'(SUBQUORUM_SIZE));
    assign arg_error  = (cmd_in == qvt_pkg::CMD_VOTE) && !in_range;

    for (genvar q = 0; q < int'(NUM_SUBQUORUMS); q++)
    begin : g_lane
        always_comb
        begin
            lane_cmd[q].clear   = accept && (cmd_in == qvt_pkg::CMD_CLEAR);
            lane_cmd[q].vote    = accept && (cmd_in == qvt_pkg::CMD_VOTE) && in_range
                                  && (int'(subq_in) == q);
            lane_cmd[q].pos     = pos_in;
            lane_cmd[q].approve = approve_in;
        end

        qvt_lane #(
            .SUBQUORUM_SIZE (SUBQUORUM_SIZE),
            .RESET_ACT      (RESET_ACT)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (lane_cmd[q]),
            .act_size ((q == 0) ? act_first_sat : act_second_sat),
            .stat     (lane_stat[q])
        );
    end

    // Tally flags from the counts as they stand after this beat.
    always_comb
    begin
        recorded       = 1'b0;
        tally_approved = 1'b1;
        tally_rejected = 1'b0;
        for (int q = 0; q < int'(NUM_SUBQUORUMS); q++)
        begin
            recorded = recorded | lane_stat[q].recorded;
            if (lane_stat[q].approve_cnt < min_votes_reg)
            begin
                tally_approved = 1'b0;
            end
            if ((5'(lane_stat[q].reject_cnt) + 5'(min_votes_reg)) > 5'(SUBQUORUM_SIZE))
            begin
                tally_rejected = 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {tally_rejected, tally_approved, arg_error, recorded};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    // A beat accepted now always has its result waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted beat produced no result");

    // A vote is never both stored and flagged out of range.
    a_no_rec_and_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("result both recorded and in error");

    // A clear neither records nor reports an error.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd_in == qvt_pkg::CMD_CLEAR)) |=> (!m_tdata[0] && !m_tdata[1]))
        else $error("clear reported a vote outcome");

endmodule
